// ----- design/winnowing_fingerprint_stream_unit_assert.svh -----
// Assertion helpers shared by the winnowing stream modules.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef WINNOWING_FINGERPRINT_STREAM_UNIT_ASSERT_SVH
`define WINNOWING_FINGERPRINT_STREAM_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/wfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wfs_pkg;

  // Storage depths.
  localparam int MAX_GRAM   = 8;
  localparam int MAX_WINDOW = 16;

  // Index and count widths that follow from the depths.
  localparam int GRAM_IDX_W = (MAX_GRAM > 1) ? $clog2(MAX_GRAM) : 1;
  localparam int FILL_W     = $clog2(MAX_GRAM + 1);
  localparam int WIN_IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_CNT_W  = $clog2(MAX_WINDOW + 1);

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int HASH_W  = 64;
  localparam int POS_W   = 32;
  localparam int BASE_W  = 8;
  localparam int GLEN_W  = 4;
  localparam int WSIZE_W = 5;

  // Character constants.
  localparam logic [BYTE_W-1:0] CHR_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CHR_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CHR_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CHR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_SHIFT  = 8'h20;
  localparam logic [HASH_W-1:0] BYTE_OFFSET = 64'd32;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register file.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_HASH_BASE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRAM_LENGTH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd2;

  localparam logic [BASE_W-1:0]  RST_HASH_BASE   = 8'd5;
  localparam logic [GLEN_W-1:0]  RST_GRAM_LENGTH = 4'd3;
  localparam logic [WSIZE_W-1:0] RST_WINDOW_SIZE = 5'd5;

  // One queued operation: a kept, lowercased byte or an end of document.
  typedef struct packed {
    logic              eod;
    logic [BYTE_W-1:0] chr;
  } wfs_op_t;

  // Configuration handed from the register file to the back end.
  typedef struct packed {
    logic [BASE_W-1:0]  hash_base;
    logic [GLEN_W-1:0]  gram_length;
    logic [WSIZE_W-1:0] win_len;
  } wfs_cfg_t;

  // Whitespace that the stream drops.
  function automatic logic is_blank(input logic [BYTE_W-1:0] chr);
    return (chr == CHR_SPACE) || (chr == CHR_NEWLINE) || (chr == CHR_TAB);
  endfunction

  // Fold A..Z to lower case, pass everything else.
  function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] chr);
    if ((chr >= CHR_UPPER_A) && (chr <= CHR_UPPER_Z)) begin
      return chr + CASE_SHIFT;
    end
    return chr;
  endfunction

  // Gram length clamped to 1..MAX_GRAM.
  function automatic logic [FILL_W-1:0] eff_gram(input logic [GLEN_W-1:0] glen);
    if (glen == '0) begin
      return FILL_W'(1);
    end
    if (int'(glen) > MAX_GRAM) begin
      return FILL_W'(MAX_GRAM);
    end
    return FILL_W'(glen);
  endfunction

  // Window size clamped to 1..MAX_WINDOW.
  function automatic logic [WIN_CNT_W-1:0] eff_window(input logic [WSIZE_W-1:0] wsize);
    if (wsize == '0) begin
      return WIN_CNT_W'(1);
    end
    if (int'(wsize) > MAX_WINDOW) begin
      return WIN_CNT_W'(MAX_WINDOW);
    end
    return WIN_CNT_W'(wsize);
  endfunction

endpackage

`default_nettype wire

// ----- design/winnowing_fingerprint_stream_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Winnowing fingerprint unit: takes document text a byte per input beat, drops space, newline
// and tab, folds A..Z to lower case, hashes every run of gram_length kept bytes as a wrapping
// 64-bit polynomial in hash_base, and over each window of the configured number of hashes
// reports the signed minimum (earliest wins ties) with its gram position whenever the selection
// changes. A beat with end_of_document set always yields one closing result, carrying the
// minimum as well when the document was shorter than one window and that minimum is new.
// Whitespace beats are dropped at the front, taken only while the queue has room. A two-entry
// queue feeds the back end, which handles one kept byte at a time and takes no new byte until
// it is done with the last: a byte that forms no gram is only stored, one that forms a gram
// is also hashed by the Horner loop (one 64x8 multiply a cycle), and once a window is full
// the window scan (one entry compared a cycle) follows. An end of document goes straight to
// the decision or first scans a short document. A finished result sits in an output register
// while the next beats are taken. Registers on the APB port: 0x0 hash_base (reset 5), 0x4
// gram_length (reset 3, used as 1..8), 0x8 window length (reset 5, used as 1..16); write them
// only while idle.
module winnowing_fingerprint_stream_unit import wfs_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // APB configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [PADDR_W-1:0]         paddr,
  input  wire logic [PDATA_W-1:0]         pwdata,
  output logic      [PDATA_W-1:0]         prdata,
  output logic                            pready,
  // Input channel
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [BYTE_W-1:0]          text_byte_i,
  input  wire logic                       end_of_document_i,
  // Output channel
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [HASH_W-1:0]        fingerprint_o,
  output logic      [POS_W-1:0]           gram_position_o,
  output logic                            fingerprint_valid_o,
  output logic                            document_end_o
);

  wfs_cfg_t              cfg_q, cfg_d;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_write;
  logic                  q_push_valid, q_push_ready;
  wfs_op_t               q_push_op;
  logic                  q_pop_valid, q_pop_ready;
  wfs_op_t               q_pop_op;
  logic [HASH_W-1:0]     fp_raw;

  // Register file: written in the access phase, read back as stored.
  assign reg_idx   = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (reg_idx)
        REG_HASH_BASE:   cfg_d.hash_base   = pwdata[BASE_W-1:0];
        REG_GRAM_LENGTH: cfg_d.gram_length = pwdata[GLEN_W-1:0];
        REG_WINDOW_SIZE: cfg_d.win_len     = pwdata[WSIZE_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HASH_BASE:   prdata = {{(PDATA_W - BASE_W){1'b0}}, cfg_q.hash_base};
      REG_GRAM_LENGTH: prdata = {{(PDATA_W - GLEN_W){1'b0}}, cfg_q.gram_length};
      REG_WINDOW_SIZE: prdata = {{(PDATA_W - WSIZE_W){1'b0}}, cfg_q.win_len};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hash_base   <= RST_HASH_BASE;
      cfg_q.gram_length <= RST_GRAM_LENGTH;
      cfg_q.win_len     <= RST_WINDOW_SIZE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify and filter input beats.
  wfs_front u_front (
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .text_byte_i       (text_byte_i),
    .end_of_document_i (end_of_document_i),
    .q_valid_o         (q_push_valid),
    .q_ready_i         (q_push_ready),
    .q_op_o            (q_push_op)
  );

  // Queue between front and back.
  wfs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_op_i    (q_push_op),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_op_o     (q_pop_op)
  );

  // Back: hashing, window scan and result register.
  wfs_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .op_valid_i          (q_pop_valid),
    .op_ready_o          (q_pop_ready),
    .op_i                (q_pop_op),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .fingerprint_o       (fp_raw),
    .gram_position_o     (gram_position_o),
    .fingerprint_valid_o (fingerprint_valid_o),
    .document_end_o      (document_end_o)
  );

  assign fingerprint_o = $signed(fp_raw);

endmodule

`default_nettype wire

// ----- design/wfs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wfs_front import wfs_pkg::*; (
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [BYTE_W-1:0] text_byte_i,
  input  wire logic              end_of_document_i,
  output logic                   q_valid_o,
  input  wire logic              q_ready_i,
  output wfs_op_t                q_op_o
);

  logic keep;

  // Whitespace beats are taken and dropped; everything else goes to the queue.
  assign keep       = end_of_document_i || !is_blank(text_byte_i);
  assign in_ready_o = q_ready_i;
  assign q_valid_o  = in_valid_i && keep;

  // End markers carry no character; kept bytes are folded to lower case.
  assign q_op_o.eod = end_of_document_i;
  assign q_op_o.chr = end_of_document_i ? '0 : to_lower(text_byte_i);

endmodule

`default_nettype wire

// ----- design/wfs_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "winnowing_fingerprint_stream_unit_assert.svh"

module wfs_queue import wfs_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_valid_i,
  output logic         push_ready_o,
  input  wire wfs_op_t push_op_i,
  output logic         pop_valid_o,
  input  wire logic    pop_ready_i,
  output wfs_op_t      pop_op_o
);

  wfs_op_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push_fire, pop_fire;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = mem_q[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  // Pointer and occupancy update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_fire && !pop_fire) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  `WFS_ASSERT_SAME(a_queue_count_bound, 1'b1, (count_q <= QCNT_W'(QUEUE_DEPTH)),
    "queue occupancy exceeds depth")
  `WFS_ASSERT_NEXT(a_queue_ptrs_agree, (count_q == '0 && !push_fire),
    (count_q == '0 && wr_ptr_q == rd_ptr_q), "empty queue pointers disagree")
  `WFS_ASSERT_SAME(a_queue_pop_nonempty, pop_fire, (count_q != '0),
    "pop from an empty queue")

endmodule

`default_nettype wire

// ----- design/wfs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "winnowing_fingerprint_stream_unit_assert.svh"

module wfs_back import wfs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wfs_cfg_t          cfg_i,
  input  wire logic              op_valid_i,
  output logic                   op_ready_o,
  input  wire wfs_op_t           op_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [HASH_W-1:0]      fingerprint_o,
  output logic [POS_W-1:0]       gram_position_o,
  output logic                   fingerprint_valid_o,
  output logic                   document_end_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HASH   = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [BYTE_W-1:0]     gram_q [MAX_GRAM];
  logic [BYTE_W-1:0]     gram_d [MAX_GRAM];
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [GRAM_IDX_W-1:0] age_q, age_d;
  logic [HASH_W-1:0]     hash_q, hash_d;
  logic [HASH_W-1:0]     win_hash_q [MAX_WINDOW];
  logic [HASH_W-1:0]     win_hash_d [MAX_WINDOW];
  logic [POS_W-1:0]      win_pos_q [MAX_WINDOW];
  logic [POS_W-1:0]      win_pos_d [MAX_WINDOW];
  logic [POS_W-1:0]      hc_q, hc_d;
  logic [POS_W-1:0]      last_pos_q, last_pos_d;
  logic                  present_q, present_d;
  logic [WIN_IDX_W-1:0]  k_q, k_d;
  logic [HASH_W-1:0]     best_hash_q, best_hash_d;
  logic [POS_W-1:0]      best_pos_q, best_pos_d;
  logic                  have_q, have_d;
  logic                  eod_q, eod_d;
  logic                  out_valid_q, out_valid_d;
  logic [HASH_W-1:0]     out_fp_q, out_fp_d;
  logic [POS_W-1:0]      out_pos_q, out_pos_d;
  logic                  out_fv_q, out_fv_d;
  logic                  out_end_q, out_end_d;

  logic [FILL_W-1:0]     glen;
  logic [FILL_W-1:0]     glen_m1;
  logic [WIN_CNT_W-1:0]  wlen;
  logic [WIN_CNT_W-1:0]  wlen_m1;
  logic [POS_W-1:0]      wlen_ext;
  logic [HASH_W-1:0]     term;
  logic [HASH_W-1:0]     h_next;
  logic [HASH_W-1:0]     sel_hash;
  logic [POS_W-1:0]      sel_pos;
  logic                  out_free;
  logic                  emit_fp;

  assign glen     = eff_gram(cfg_i.gram_length);
  assign glen_m1  = glen - FILL_W'(1);
  assign wlen     = eff_window(cfg_i.win_len);
  assign wlen_m1  = wlen - WIN_CNT_W'(1);
  assign wlen_ext = {{(POS_W - WIN_CNT_W){1'b0}}, wlen};

  // One Horner step a cycle: newest byte first, oldest byte lands at base^0.
  assign term   = {{(HASH_W - BYTE_W){1'b0}}, gram_q[age_q]} - BYTE_OFFSET;
  assign h_next = (hash_q * cfg_i.hash_base) + term;

  // Window entry under the scan index.
  assign sel_hash = win_hash_q[k_q];
  assign sel_pos  = win_pos_q[k_q];

  assign out_free   = !out_valid_q || out_ready_i;
  assign emit_fp    = have_q && (!present_q || (best_pos_q != last_pos_q));
  assign op_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    gram_d      = gram_q;
    fill_d      = fill_q;
    age_d       = age_q;
    hash_d      = hash_q;
    win_hash_d  = win_hash_q;
    win_pos_d   = win_pos_q;
    hc_d        = hc_q;
    last_pos_d  = last_pos_q;
    present_d   = present_q;
    k_d         = k_q;
    best_hash_d = best_hash_q;
    best_pos_d  = best_pos_q;
    have_d      = have_q;
    eod_d       = eod_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_fp_d    = out_fp_q;
    out_pos_d   = out_pos_q;
    out_fv_d    = out_fv_q;
    out_end_d   = out_end_q;

    case (state_q)
      // Take one operation from the queue.
      S_IDLE: begin
        if (op_valid_i) begin
          if (op_i.eod) begin
            eod_d = 1'b1;
            if ((hc_q != '0) && (hc_q < wlen_ext)) begin
              // Short document: scan what has been hashed so far.
              have_d  = 1'b1;
              k_d     = hc_q[WIN_IDX_W-1:0] - WIN_IDX_W'(1);
              state_d = S_LOAD;
            end else begin
              have_d  = 1'b0;
              state_d = S_DECIDE;
            end
          end else begin
            eod_d     = 1'b0;
            gram_d[0] = op_i.chr;
            for (int i = 1; i < MAX_GRAM; i++) begin
              gram_d[i] = gram_q[i-1];
            end
            if (fill_q < FILL_W'(MAX_GRAM)) begin
              fill_d = fill_q + FILL_W'(1);
            end
            if (fill_d >= glen) begin
              hash_d  = '0;
              age_d   = '0;
              state_d = S_HASH;
            end
          end
        end
      end

      // Accumulate the gram hash; the last step pushes it into the window.
      S_HASH: begin
        hash_d = h_next;
        if (age_q == glen_m1[GRAM_IDX_W-1:0]) begin
          win_hash_d[0] = h_next;
          win_pos_d[0]  = hc_q;
          for (int i = 1; i < MAX_WINDOW; i++) begin
            win_hash_d[i] = win_hash_q[i-1];
            win_pos_d[i]  = win_pos_q[i-1];
          end
          if (hc_q != '1) begin
            hc_d = hc_q + POS_W'(1);
          end
          if (hc_d >= wlen_ext) begin
            have_d  = 1'b1;
            k_d     = wlen_m1[WIN_IDX_W-1:0];
            state_d = S_LOAD;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          age_d = age_q + GRAM_IDX_W'(1);
        end
      end

      // The oldest entry in range starts as the candidate.
      S_LOAD: begin
        best_hash_d = sel_hash;
        best_pos_d  = sel_pos;
        if (k_q == '0) begin
          state_d = S_DECIDE;
        end else begin
          k_d     = k_q - WIN_IDX_W'(1);
          state_d = S_SCAN;
        end
      end

      // Walk toward the newest entry; only a strictly smaller hash replaces.
      S_SCAN: begin
        if ($signed(sel_hash) < $signed(best_hash_q)) begin
          best_hash_d = sel_hash;
          best_pos_d  = sel_pos;
        end
        if (k_q == '0) begin
          state_d = S_DECIDE;
        end else begin
          k_d = k_q - WIN_IDX_W'(1);
        end
      end

      // Emit a new minimum and/or the end marker once the output is free.
      S_DECIDE: begin
        if (emit_fp || eod_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_fv_d    = emit_fp;
            out_end_d   = eod_q;
            out_fp_d    = emit_fp ? best_hash_q : '0;
            out_pos_d   = emit_fp ? best_pos_q : '0;
            if (emit_fp) begin
              last_pos_d = best_pos_q;
              present_d  = 1'b1;
            end
            if (eod_q) begin
              fill_d     = '0;
              hc_d       = '0;
              last_pos_d = '0;
              present_d  = 1'b0;
            end
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      age_q       <= '0;
      hc_q        <= '0;
      last_pos_q  <= '0;
      present_q   <= 1'b0;
      k_q         <= '0;
      have_q      <= 1'b0;
      eod_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      age_q       <= age_d;
      hc_q        <= hc_d;
      last_pos_q  <= last_pos_d;
      present_q   <= present_d;
      k_q         <= k_d;
      have_q      <= have_d;
      eod_q       <= eod_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: gram and window stores, candidate and result registers.
  always_ff @(posedge clk_i) begin
    gram_q      <= gram_d;
    hash_q      <= hash_d;
    win_hash_q  <= win_hash_d;
    win_pos_q   <= win_pos_d;
    best_hash_q <= best_hash_d;
    best_pos_q  <= best_pos_d;
    out_fp_q    <= out_fp_d;
    out_pos_q   <= out_pos_d;
    out_fv_q    <= out_fv_d;
    out_end_q   <= out_end_d;
  end

  assign out_valid_o         = out_valid_q;
  assign fingerprint_o       = out_fp_q;
  assign gram_position_o     = out_pos_q;
  assign fingerprint_valid_o = out_fv_q;
  assign document_end_o      = out_end_q;

  `WFS_ASSERT_NEXT(a_end_clears_stream, (state_q == S_DECIDE && eod_q && out_free),
    (hc_q == '0 && fill_q == '0 && !present_q && out_end_q),
    "end of document did not clear stream")
  `WFS_ASSERT_SAME(a_empty_result_zero, (out_valid_q && !out_fv_q),
    (out_fp_q == '0 && out_pos_q == '0 && out_end_q),
    "result without fingerprint is not a clean end marker")
  `WFS_ASSERT_SAME(a_fill_bound, 1'b1, (fill_q <= FILL_W'(MAX_GRAM)),
    "gram fill above its depth")
  `WFS_ASSERT_NEXT(a_no_pop_while_busy, (state_q != S_IDLE && state_q != S_DECIDE),
    (state_q != S_IDLE || $past(state_q) != S_LOAD), "left a scan without deciding")

endmodule

`default_nettype wire
